// File: src/ppdmm_pkg.sv
`timescale 1ns / 1ps

package ppdmm_pkg;

  // pipeline layout
  localparam int NumStages  = 10;
  localparam int StgProd    = 0;
  localparam int StgTau     = 1;
  localparam int StgTilt    = 2;
  localparam int StgMix     = 3;
  localparam int StgRoot    = 4;
  localparam int RootStages = 5;
  localparam int StgCmd     = 9;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    RegPitchTarget   = 3'd0,
    RegPropGain      = 3'd1,
    RegDerivGain     = 3'd2,
    RegTiltMixGain   = 3'd3,
    RegThrustMixGain = 3'd4,
    RegMaxSpeedSq    = 3'd5,
    RegMinSpeedSq    = 3'd6
  } reg_idx_t;

  typedef logic signed [15:0] angle_t;
  typedef logic        [15:0] thrust_t;
  typedef logic        [15:0] gain_t;
  typedef logic        [19:0] mix_gain_t;
  typedef logic        [19:0] sq_t;
  typedef logic signed [33:0] sq_wide_t;
  typedef logic signed [22:0] tau_t;
  typedef logic signed [43:0] tilt_t;
  typedef logic        [31:0] thr_t;
  typedef logic        [9:0]  root_t;
  typedef logic        [11:0] rem_t;
  typedef logic        [7:0]  cmd_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
  } sqrt_acc_t;

  localparam logic [13:0] SlopeQ16  = 14'd15626;
  localparam logic [20:0] OffsetQ16 = 21'd1695589;
  localparam cmd_t        CmdMin    = 8'd1;
  localparam cmd_t        CmdMax    = 8'd200;

  localparam angle_t    PitchTargetRst   = 16'sd0;
  localparam gain_t     PropGainRst      = 16'd4096;
  localparam gain_t     DerivGainRst     = 16'd1229;
  localparam mix_gain_t TiltMixGainRst   = 20'd144706;
  localparam gain_t     ThrustMixGainRst = 16'd15557;
  localparam sq_t       MaxSpeedSqRst    = 20'd607720;
  localparam sq_t       MinSpeedSqRst    = 20'd12703;

  // one restoring step of the digit-by-digit square root
  function automatic sqrt_acc_t isqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [13:0] rem_sh;
    logic [13:0] trial;
    sqrt_acc_t   res;
    rem_sh = {acc.rem, pair};
    trial  = {2'b00, acc.root, 2'b01};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh[11:0] - trial[11:0];
      res.root = {acc.root[8:0], 1'b1};
    end else begin
      res.rem  = rem_sh[11:0];
      res.root = {acc.root[8:0], 1'b0};
    end
    return res;
  endfunction

  // max test first: with crossed limits, values above the max give the max, all others the min
  function automatic sq_t clamp_sq(sq_wide_t w, sq_t mx, sq_t mn);
    if (w > $signed({14'b0, mx})) begin
      return mx;
    end else if (w < $signed({14'b0, mn})) begin
      return mn;
    end
    return w[19:0];
  endfunction

  function automatic cmd_t to_cmd(root_t s);
    logic        [23:0] prod;
    logic signed [24:0] diff;
    cmd_t               c;
    prod = {10'b0, SlopeQ16} * {14'b0, s};
    diff = $signed({1'b0, prod}) - $signed({4'b0, OffsetQ16});
    c    = diff[23:16];
    if (diff[24]) begin
      return CmdMin;
    end else if (c < CmdMin) begin
      return CmdMin;
    end else if (c > CmdMax) begin
      return CmdMax;
    end
    return c;
  endfunction

endpackage

// File: src/ppdmm_if.sv
`timescale 1ns / 1ps

interface ppdmm_in_if;
  import ppdmm_pkg::*;
  logic    valid;
  logic    ready;
  angle_t  pitch_angle;
  angle_t  pitch_rate;
  thrust_t thrust;

  modport source (output valid, output pitch_angle, output pitch_rate, output thrust,
                  input ready);
  modport sink   (input valid, input pitch_angle, input pitch_rate, input thrust,
                  output ready);
endinterface

interface ppdmm_out_if;
  import ppdmm_pkg::*;
  logic valid;
  logic ready;
  cmd_t motor_zero;
  cmd_t motor_one;
  cmd_t motor_two;
  cmd_t motor_three;

  modport source (output valid, output motor_zero, output motor_one, output motor_two,
                  output motor_three, input ready);
  modport sink   (input valid, input motor_zero, input motor_one, input motor_two,
                  input motor_three, output ready);
endinterface

// File: src/ppdmm_pd.sv
`timescale 1ns / 1ps

module ppdmm_pd (
  input  logic               clk,
  input  logic [2:0]         en,
  input  ppdmm_pkg::angle_t  pitch_angle,
  input  ppdmm_pkg::angle_t  pitch_rate,
  input  ppdmm_pkg::thrust_t thrust,
  input  ppdmm_pkg::angle_t  pitch_target,
  input  ppdmm_pkg::gain_t   prop_gain,
  input  ppdmm_pkg::gain_t   deriv_gain,
  input  ppdmm_pkg::mix_gain_t tilt_mix_gain,
  input  ppdmm_pkg::gain_t   thrust_mix_gain,
  output ppdmm_pkg::tilt_t   tilt,
  output ppdmm_pkg::thr_t    thr
);
  import ppdmm_pkg::*;

  logic signed [16:0] err;
  logic signed [33:0] p_nxt, d_nxt, p_r, d_r;
  thr_t               thr1_nxt, thr1_r, thr2_r, thr3_r;
  logic signed [34:0] diff;
  tau_t               tau_nxt, tau_r;
  tilt_t              tilt_nxt, tilt_r;

  // stage 1: gain products
  always_comb begin
    err      = {pitch_target[15], pitch_target} - {pitch_angle[15], pitch_angle};
    p_nxt    = $signed({18'b0, prop_gain}) * $signed({{17{err[16]}}, err});
    d_nxt    = $signed({18'b0, deriv_gain}) * $signed({{18{pitch_rate[15]}}, pitch_rate});
    thr1_nxt = {16'b0, thrust_mix_gain} * {16'b0, thrust};
  end

  // stage 2: torque, rounded half up to q.12
  always_comb begin
    diff    = {p_r[33], p_r} - {d_r[33], d_r} + 35'sd2048;
    tau_nxt = diff[34:12];
  end

  // stage 3: tilt share of speed squared
  assign tilt_nxt = $signed({24'b0, tilt_mix_gain}) * $signed({{21{tau_r[22]}}, tau_r});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r    <= p_nxt;
      d_r    <= d_nxt;
      thr1_r <= thr1_nxt;
    end
    if (en[1]) begin
      tau_r  <= tau_nxt;
      thr2_r <= thr1_r;
    end
    if (en[2]) begin
      tilt_r <= tilt_nxt;
      thr3_r <= thr2_r;
    end
  end

  assign tilt = tilt_r;
  assign thr  = thr3_r;

endmodule

// File: src/ppdmm_mix.sv
`timescale 1ns / 1ps

module ppdmm_mix (
  input  logic              clk,
  input  logic              en,
  input  ppdmm_pkg::tilt_t  tilt,
  input  ppdmm_pkg::thr_t   thr,
  input  ppdmm_pkg::sq_t    max_speed_sq,
  input  ppdmm_pkg::sq_t    min_speed_sq,
  output ppdmm_pkg::sq_t    sq_front,
  output ppdmm_pkg::sq_t    sq_side,
  output ppdmm_pkg::sq_t    sq_back
);
  import ppdmm_pkg::*;

  logic signed [45:0] thr_s, tilt_s, sum_front, sum_side, sum_back;
  sq_t                front_nxt, side_nxt, back_nxt;
  sq_t                front_r, side_r, back_r;

  always_comb begin
    thr_s     = $signed({10'b0, thr, 4'b0});
    tilt_s    = {{2{tilt[43]}}, tilt};
    sum_front = thr_s + tilt_s + 46'sd2048;
    sum_side  = thr_s + 46'sd2048;
    sum_back  = thr_s - tilt_s + 46'sd2048;
    front_nxt = clamp_sq(sum_front[45:12], max_speed_sq, min_speed_sq);
    side_nxt  = clamp_sq(sum_side[45:12], max_speed_sq, min_speed_sq);
    back_nxt  = clamp_sq(sum_back[45:12], max_speed_sq, min_speed_sq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
      side_r  <= side_nxt;
      back_r  <= back_nxt;
    end
  end

  assign sq_front = front_r;
  assign sq_side  = side_r;
  assign sq_back  = back_r;

endmodule

// File: src/ppdmm_isqrt.sv
`timescale 1ns / 1ps

module ppdmm_isqrt (
  input  logic                                clk,
  input  logic [ppdmm_pkg::RootStages-1:0]    en,
  input  ppdmm_pkg::sq_t                      sq,
  output ppdmm_pkg::root_t                    root
);
  import ppdmm_pkg::*;

  sqrt_acc_t acc_r  [RootStages];
  sq_t       rest_r [RootStages-1];

  // two result bits per stage, radicand consumed from the top
  for (genvar g = 0; g < RootStages; g++) begin : g_stage
    sqrt_acc_t acc_in, acc_mid, acc_nxt;
    sq_t       bits_in;

    if (g == 0) begin : g_first
      assign acc_in  = '0;
      assign bits_in = sq;
    end else begin : g_next
      assign acc_in  = acc_r[g-1];
      assign bits_in = rest_r[g-1];
    end

    assign acc_mid = isqrt_step(acc_in, bits_in[19:18]);
    assign acc_nxt = isqrt_step(acc_mid, bits_in[17:16]);

    always_ff @(posedge clk) begin
      if (en[g]) begin
        acc_r[g] <= acc_nxt;
      end
    end

    if (g < RootStages - 1) begin : g_rest
      always_ff @(posedge clk) begin
        if (en[g]) begin
          rest_r[g] <= {bits_in[15:0], 4'b0};
        end
      end
    end
  end

  assign root = acc_r[RootStages-1].root;

endmodule

// File: src/ppdmm_cmd.sv
`timescale 1ns / 1ps

module ppdmm_cmd (
  input  logic              clk,
  input  logic              en,
  input  ppdmm_pkg::root_t  root_front,
  input  ppdmm_pkg::root_t  root_side,
  input  ppdmm_pkg::root_t  root_back,
  output ppdmm_pkg::cmd_t   cmd_front,
  output ppdmm_pkg::cmd_t   cmd_side,
  output ppdmm_pkg::cmd_t   cmd_back
);
  import ppdmm_pkg::*;

  cmd_t front_r, side_r, back_r;

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= to_cmd(root_front);
      side_r  <= to_cmd(root_side);
      back_r  <= to_cmd(root_back);
    end
  end

  assign cmd_front = front_r;
  assign cmd_side  = side_r;
  assign cmd_back  = back_r;

endmodule

// File: src/pitch_pd_quadrotor_motor_mixer.sv
`timescale 1ns / 1ps

// pitch pd controller and plus-frame motor mixer
// in_ch carries one imu item (pitch angle, pitch rate, thrust) per handshake;
// out_ch returns the four motor commands (1..200) for that item, in order.
// the cfg_ port writes the gains, pitch target and speed-squared limits;
// write only while no item is in flight.
// pipeline: 10 register stages (products, torque, tilt, mix and clamp,
// five square-root stages of two bits each, command map into the output
// register).
// throughput: one item per cycle while out_ch.ready is high or some stage is
// empty; every stage holds one item.
// stalls: each stage carries its own valid bit and moves on when the stage
// ahead is empty or moving, so bubbles close up and in_ch.ready only drops
// once every stage holds an item and out_ch.ready is low.
// reset (rst_n low, synchronous) empties the pipeline and loads the default
// gains and limits.
module pitch_pd_quadrotor_motor_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  ppdmm_in_if.sink                      in_ch,
  ppdmm_out_if.source                   out_ch,
  input  logic                          cfg_wr_en,
  input  logic [ppdmm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ppdmm_pkg::CfgDataW-1:0] cfg_wr_data
);
  import ppdmm_pkg::*;

  angle_t    pitch_target_r;
  gain_t     prop_gain_r, deriv_gain_r, thrust_mix_gain_r;
  mix_gain_t tilt_mix_gain_r;
  sq_t       max_speed_sq_r, min_speed_sq_r;

  logic [NumStages-1:0] v_r;
  logic [NumStages-1:0] en;

  tilt_t tilt;
  thr_t  thr;
  sq_t   sq_front, sq_side, sq_back;
  root_t root_front, root_side, root_back;
  cmd_t  cmd_front, cmd_side, cmd_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_target_r    <= PitchTargetRst;
      prop_gain_r       <= PropGainRst;
      deriv_gain_r      <= DerivGainRst;
      tilt_mix_gain_r   <= TiltMixGainRst;
      thrust_mix_gain_r <= ThrustMixGainRst;
      max_speed_sq_r    <= MaxSpeedSqRst;
      min_speed_sq_r    <= MinSpeedSqRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegPitchTarget:   pitch_target_r    <= signed'(cfg_wr_data[15:0]);
        RegPropGain:      prop_gain_r       <= cfg_wr_data[15:0];
        RegDerivGain:     deriv_gain_r      <= cfg_wr_data[15:0];
        RegTiltMixGain:   tilt_mix_gain_r   <= cfg_wr_data;
        RegThrustMixGain: thrust_mix_gain_r <= cfg_wr_data[15:0];
        RegMaxSpeedSq:    max_speed_sq_r    <= cfg_wr_data;
        RegMinSpeedSq:    min_speed_sq_r    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage ahead is loading
  always_comb begin
    en[NumStages-1] = !v_r[NumStages-1] || out_ch.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[StgProd];

  ppdmm_pd u_pd (
    .clk             (clk),
    .en              (en[StgTilt:StgProd]),
    .pitch_angle     (in_ch.pitch_angle),
    .pitch_rate      (in_ch.pitch_rate),
    .thrust          (in_ch.thrust),
    .pitch_target    (pitch_target_r),
    .prop_gain       (prop_gain_r),
    .deriv_gain      (deriv_gain_r),
    .tilt_mix_gain   (tilt_mix_gain_r),
    .thrust_mix_gain (thrust_mix_gain_r),
    .tilt            (tilt),
    .thr             (thr)
  );

  ppdmm_mix u_mix (
    .clk          (clk),
    .en           (en[StgMix]),
    .tilt         (tilt),
    .thr          (thr),
    .max_speed_sq (max_speed_sq_r),
    .min_speed_sq (min_speed_sq_r),
    .sq_front     (sq_front),
    .sq_side      (sq_side),
    .sq_back      (sq_back)
  );

  ppdmm_isqrt u_isqrt_front (
    .clk  (clk),
    .en   (en[StgRoot+RootStages-1:StgRoot]),
    .sq   (sq_front),
    .root (root_front)
  );

  ppdmm_isqrt u_isqrt_side (
    .clk  (clk),
    .en   (en[StgRoot+RootStages-1:StgRoot]),
    .sq   (sq_side),
    .root (root_side)
  );

  ppdmm_isqrt u_isqrt_back (
    .clk  (clk),
    .en   (en[StgRoot+RootStages-1:StgRoot]),
    .sq   (sq_back),
    .root (root_back)
  );

  ppdmm_cmd u_cmd (
    .clk        (clk),
    .en         (en[StgCmd]),
    .root_front (root_front),
    .root_side  (root_side),
    .root_back  (root_back),
    .cmd_front  (cmd_front),
    .cmd_side   (cmd_side),
    .cmd_back   (cmd_back)
  );

  // slot order: rotor 0, rotor 2, rotor 3, rotor 1; rotors 1 and 3 agree
  assign out_ch.valid       = v_r[StgCmd];
  assign out_ch.motor_zero  = cmd_front;
  assign out_ch.motor_one   = cmd_back;
  assign out_ch.motor_two   = cmd_side;
  assign out_ch.motor_three = cmd_side;

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r) && !out_ch.ready)
    else $error("input blocked while the pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[StgProd])
    else $error("accepted item did not enter the first stage");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.motor_zero >= CmdMin && out_ch.motor_zero <= CmdMax &&
                      out_ch.motor_one >= CmdMin && out_ch.motor_one <= CmdMax &&
                      out_ch.motor_two >= CmdMin && out_ch.motor_two <= CmdMax))
    else $error("motor command out of range");

  a_stalled_stage_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[StgMix] && !en[StgMix]) |=> v_r[StgMix] && $stable(sq_front))
    else $error("stalled mix stage lost its item");
`endif

endmodule

// File: dv/tb_pitch_pd_quadrotor_motor_mixer.sv
`timescale 1ns / 1ps

module tb_pitch_pd_quadrotor_motor_mixer;
  import ppdmm_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int          DrainCycles = 14;
  localparam int          MaxPrinted  = 200;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpareIdx = 3'd7;

  // speed-to-command map, Q16
  localparam longint CmdSlopeQ16  = 15626;
  localparam longint CmdOffsetQ16 = 1695589;
  localparam longint CmdLow       = 1;
  localparam longint CmdHigh      = 200;

  // slot k holds the command for motor slot k
  typedef logic [3:0][7:0] motor_set_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wr_data;

  ppdmm_in_if  in_ch ();
  ppdmm_out_if out_ch ();

  pitch_pd_quadrotor_motor_mixer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies for the predictor
  angle_t    cur_target;
  gain_t     cur_prop_gain;
  gain_t     cur_deriv_gain;
  mix_gain_t cur_tilt_gain;
  gain_t     cur_thrust_gain;
  sq_t       cur_max_sq;
  sq_t       cur_min_sq;

  motor_set_t  expected_cmds[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          src_idle_en    = 1'b1;
  bit          sink_stall_en  = 1'b1;
  int          hold_off_cycles = 0;
  string       slot_name [4] = '{"motor_zero", "motor_one", "motor_two", "motor_three"};

  function automatic longint q12_round_off(longint x);
    return (x + 64'sd2048) >>> 12;
  endfunction

  function automatic sq_t limit_speed_sq(longint w);
    if (w > longint'(cur_max_sq)) begin
      return cur_max_sq;
    end else if (w < longint'(cur_min_sq)) begin
      return cur_min_sq;
    end
    return sq_t'(w);
  endfunction

  function automatic cmd_t speed_sq_to_cmd(sq_t sq);
    int     root;
    longint scaled;
    root = 0;
    for (int b = 512; b > 0; b = b / 2) begin
      if ((root + b) * (root + b) <= int'(sq)) begin
        root = root + b;
      end
    end
    scaled = CmdSlopeQ16 * root - CmdOffsetQ16;
    if (scaled < 0) begin
      return cmd_t'(CmdLow);
    end
    scaled = scaled / 65536;
    if (scaled < CmdLow) begin
      return cmd_t'(CmdLow);
    end else if (scaled > CmdHigh) begin
      return cmd_t'(CmdHigh);
    end
    return cmd_t'(scaled);
  endfunction

  function automatic motor_set_t predict_motors(angle_t angle, angle_t rate, thrust_t thrust);
    longint     err;
    longint     torque;
    longint     tilt;
    longint     lift;
    sq_t        sq_front;
    sq_t        sq_side;
    sq_t        sq_back;
    motor_set_t cmds;
    err    = longint'(cur_target) - longint'(angle);
    torque = q12_round_off(longint'(cur_prop_gain) * err
                           - longint'(cur_deriv_gain) * longint'(rate));
    tilt   = longint'(cur_tilt_gain) * torque;
    lift   = longint'(cur_thrust_gain) * longint'(thrust) * 16;
    sq_front = limit_speed_sq(q12_round_off(lift + tilt));
    sq_side  = limit_speed_sq(q12_round_off(lift));
    sq_back  = limit_speed_sq(q12_round_off(lift - tilt));
    // slots 0..3 come from rotors 0, 2, 3, 1; rotors 1 and 3 see thrust only
    cmds[0] = speed_sq_to_cmd(sq_front);
    cmds[1] = speed_sq_to_cmd(sq_back);
    cmds[2] = speed_sq_to_cmd(sq_side);
    cmds[3] = cmds[2];
    return cmds;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = data;
    case (idx)
      RegPitchTarget:   cur_target      = data[15:0];
      RegPropGain:      cur_prop_gain   = data[15:0];
      RegDerivGain:     cur_deriv_gain  = data[15:0];
      RegTiltMixGain:   cur_tilt_gain   = data;
      RegThrustMixGain: cur_thrust_gain = data[15:0];
      RegMaxSpeedSq:    cur_max_sq      = data;
      RegMinSpeedSq:    cur_min_sq      = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_all_regs(logic [19:0] tgt, logic [19:0] kp, logic [19:0] kd,
                                logic [19:0] tilt, logic [19:0] thrk, logic [19:0] mx,
                                logic [19:0] mn);
    cfg_write(RegPitchTarget, tgt);
    cfg_write(RegPropGain, kp);
    cfg_write(RegDerivGain, kd);
    cfg_write(RegTiltMixGain, tilt);
    cfg_write(RegThrustMixGain, thrk);
    cfg_write(RegMaxSpeedSq, mx);
    cfg_write(RegMinSpeedSq, mn);
  endtask

  // wait until the pipeline has handed back everything
  task automatic settle_pipeline();
    while (expected_cmds.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  // called just after a falling edge; returns just after a falling edge
  task automatic send_item(angle_t angle, angle_t rate, thrust_t thrust);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.pitch_angle = angle;
    in_ch.pitch_rate  = rate;
    in_ch.thrust      = thrust;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    expected_cmds.push_back(predict_motors(angle, rate, thrust));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_signed_word(int span);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  task automatic send_random_item();
    logic [15:0] angle;
    logic [15:0] rate;
    logic [15:0] thrust;
    angle = pick_signed_word(6000);
    rate  = pick_signed_word(8000);
    case ($urandom_range(0, 7))
      0: thrust = 16'($urandom());
      1: thrust = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: thrust = 16'($urandom_range(0, 12000));
    endcase
    send_item(angle, rate, thrust);
  endtask

  task automatic pick_random_settings();
    case ($urandom_range(0, 6))
      0: write_all_regs(20'd0, 20'd4096, 20'd1229, 20'd144706, 20'd15557, 20'd607720,
                        20'd12703);
      1: write_all_regs(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
      2: write_all_regs(20'h07FFF, 20'hFFFF, 20'hFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFFF,
                        20'd0);
      3: write_all_regs(20'($urandom()), 20'($urandom()), 20'($urandom()),
                        20'($urandom()), 20'($urandom()), 20'($urandom()),
                        20'($urandom()));
      default: write_all_regs(20'($urandom_range(0, 8192) - 4096),
                              20'($urandom_range(0, 16383)),
                              20'($urandom_range(0, 8191)),
                              20'($urandom_range(0, 400000)),
                              20'($urandom_range(0, 32767)),
                              20'($urandom_range(200000, 1048575)),
                              20'($urandom_range(0, 60000)));
    endcase
  endtask

  task automatic test_field_extremes();
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'h0000, 16'hFFFF);
    send_item(16'h7FFF, 16'h7FFF, 16'h0000);
    send_item(16'h8000, 16'h8000, 16'hFFFF);
    send_item(16'h7FFF, 16'h8000, 16'd5000);
    send_item(16'h8000, 16'h7FFF, 16'd5000);
    send_item(16'h0400, 16'h0000, 16'd4000);
    send_item(16'hFC00, 16'h0000, 16'd4000);
    send_item(16'h0000, 16'h1000, 16'd8000);
    send_item(16'h0000, 16'h0000, 16'd209);
  endtask

  task automatic test_clamp_cases();
    // limits crossed: values above the upper limit get it, all others the lower limit
    settle_pipeline();
    cfg_write(RegMinSpeedSq, 20'd900000);
    cfg_write(RegMaxSpeedSq, 20'd1000);
    send_item(16'h0000, 16'h0000, 16'd0);
    send_item(16'h0200, 16'h0000, 16'd6000);
    send_item(16'h0000, 16'h0000, 16'hFFFF);
    // widest limits, commands hit both ends
    settle_pipeline();
    write_all_regs(20'd0, 20'd4096, 20'd1229, 20'hFFFFF, 20'hFFFF, 20'hFFFFF, 20'd0);
    send_item(16'h7FFF, 16'h0000, 16'd3000);
    send_item(16'h8000, 16'h0000, 16'hFFFF);
    // both limits at zero
    settle_pipeline();
    cfg_write(RegMaxSpeedSq, 20'd0);
    send_item(16'h1234, 16'hF00D, 16'd9000);
  endtask

  task automatic test_register_handling();
    settle_pipeline();
    cfg_write(RegSpareIdx, 20'hFFFFF);
    // bits above each register's width are dropped
    write_all_regs(20'hA8000, 20'hF2000, 20'hFFFFF, 20'd144706, 20'h53CC5, 20'd607720,
                   20'd12703);
    send_item(16'h0000, 16'h0100, 16'd5000);
    send_item(16'h9000, 16'hF000, 16'd2500);
    send_item(16'h7000, 16'h0800, 16'd7000);
    settle_pipeline();
    write_all_regs(20'd0, 20'd4096, 20'd1229, 20'd144706, 20'd15557, 20'd607720, 20'd12703);
  endtask

  task automatic test_output_backpressure();
    src_idle_en     = 1'b0;
    hold_off_cycles = 80;
    repeat (40) send_random_item();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      settle_pipeline();
      pick_random_settings();
      src_idle_en   = ($urandom_range(0, 3) != 0);
      sink_stall_en = ($urandom_range(0, 3) != 0);
      repeat (100) send_random_item();
    end
  endtask

  task automatic test_full_rate_stream();
    settle_pipeline();
    pick_random_settings();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    repeat (190) send_random_item();
  endtask

  // result sink: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready = 1'b0;
        for (int n = 1; n < hold_off_cycles; n++) begin
          @(negedge clk);
        end
        hold_off_cycles = 0;
      end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    motor_set_t got;
    motor_set_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.motor_three, out_ch.motor_two, out_ch.motor_one, out_ch.motor_zero};
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("result %h with no item waiting", got));
      end else begin
        want = expected_cmds.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("%s got %0d want %0d", slot_name[k], got[k],
                                      want[k]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.pitch_angle = '0;
    in_ch.pitch_rate  = '0;
    in_ch.thrust      = '0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wr_data       = '0;
    cur_target        = 16'sd0;
    cur_prop_gain     = 16'd4096;
    cur_deriv_gain    = 16'd1229;
    cur_tilt_gain     = 20'd144706;
    cur_thrust_gain   = 16'd15557;
    cur_max_sq        = 20'd607720;
    cur_min_sq        = 20'd12703;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_clamp_cases();
    test_register_handling();
    test_output_backpressure();
    test_random_settings();
    test_full_rate_stream();

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
